/* sv/ccs_pkg.sv */
// shared constants and helpers of the clock calendar setter
// command codes, field codes, counter widths and bcd conversion
// no dependencies
`default_nettype none

package ccs_pkg;

    // command codes carried in tuser
    localparam logic [2:0] CMD_TOGGLE = 3'd0;
    localparam logic [2:0] CMD_NEXT   = 3'd1;
    localparam logic [2:0] CMD_INC    = 3'd2;
    localparam logic [2:0] CMD_DEC    = 3'd3;
    localparam logic [2:0] CMD_LOAD   = 3'd4;

    // selected field codes
    localparam logic [2:0] FLD_NONE   = 3'd0;
    localparam logic [2:0] FLD_SECOND = 3'd1;
    localparam logic [2:0] FLD_MINUTE = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_DAY    = 3'd4;
    localparam logic [2:0] FLD_MONTH  = 3'd5;
    localparam logic [2:0] FLD_YEAR   = 3'd6;

    // counter limits
    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [4:0] DAY_MAX   = 5'd31;
    localparam logic [4:0] DAY_30    = 5'd30;
    localparam logic [4:0] DAY_29    = 5'd29;
    localparam logic [4:0] DAY_28    = 5'd28;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [6:0] YEAR_MAX  = 7'd99;

    // stream widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int CMD_W      = 3;

    // two bcd nibbles to binary, nibbles above 9 taken as hi*10+lo (max 165)
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] tens;
        tens = {4'd0, v[7:4]} * 8'd10;
        return tens + {4'd0, v[3:0]};
    endfunction

    // binary 0..99 to two bcd nibbles, divide by 10 via reciprocal multiply
    function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = {8'd0, v} * 15'd205;
        tens = prod[14:11];
        ones = v - 7'({3'd0, tens} * 7'd10);
        return {tens, ones[3:0]};
    endfunction

endpackage

`default_nettype wire

/* sv/clock_calendar_setter_top.sv */
// clock calendar setter, top level
// depends on ccs_pkg for command codes, field codes and bcd helpers
`default_nettype none

// Clock/calendar setter. Each input beat carries one event in s_axis_tuser:
// toggle set mode, next field, increment, decrement or load. Toggle enters
// set mode with seconds selected, or leaves it and clears the selection.
// Next steps the selection second, minute, hour, day, month, year and back
// to second; increment and decrement wrap the selected field, and the day
// wraps at the month's length (30, 31, or 28/29 for February with the leap
// test on the two-digit year divisible by four). Next, increment and
// decrement act only in set mode; load acts only outside it and clamps each
// bcd value into its field's range. Every input beat gives exactly one
// output beat with the set flag, the selected field and all six counters in
// bcd. The counters update on the accepting edge, so one beat is taken per
// clock unless the output stalls; each output beat appears in the cycle
// after its input beat, and the single output register is the only
// buffering: input is taken whenever it is empty or drained in that cycle.
module clock_calendar_setter_top
    import ccs_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input stream
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: load_second[7:0], load_minute, load_hour, load_day, load_month,
    //        load_year[47:40]
    input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: cmd[2:0]
    input  wire  [CMD_W-1:0]      s_axis_tuser,
    // output stream
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // tdata: setting[0], selected_field[3:1], second_bcd[10:4],
    //        minute_bcd[17:11], hour_bcd[23:18], day_bcd[29:24],
    //        month_bcd[34:30], year_bcd[42:35], zero pad[47:43]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // state registers
    logic       r_set,    n_set;
    logic [2:0] r_sel,    n_sel;
    logic [5:0] r_second, n_second;
    logic [5:0] r_minute, n_minute;
    logic [4:0] r_hour,   n_hour;
    logic [4:0] r_day,    n_day;
    logic [3:0] r_month,  n_month;
    logic [6:0] r_year,   n_year;
    logic       r_out_valid;

    logic       accept;
    logic [4:0] day_lim;

    // load values converted and clamped
    logic [7:0] ld_sec, ld_min, ld_hour, ld_day, ld_month, ld_year;

    // output register empty or draining this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // days in the current month
    always_comb begin
        if (r_month == 4'd4 || r_month == 4'd6 || r_month == 4'd9 ||
            r_month == 4'd11) begin
            day_lim = DAY_30;
        end else if (r_month == 4'd2) begin
            day_lim = (r_year[1:0] == 2'd0) ? DAY_29 : DAY_28;
        end else begin
            day_lim = DAY_MAX;
        end
    end

    assign ld_sec   = bcd_to_bin(s_axis_tdata[7:0]);
    assign ld_min   = bcd_to_bin(s_axis_tdata[15:8]);
    assign ld_hour  = bcd_to_bin(s_axis_tdata[23:16]);
    assign ld_day   = bcd_to_bin(s_axis_tdata[31:24]);
    assign ld_month = bcd_to_bin(s_axis_tdata[39:32]);
    assign ld_year  = bcd_to_bin(s_axis_tdata[47:40]);

    // next state for one event
    always_comb begin
        n_set    = r_set;
        n_sel    = r_sel;
        n_second = r_second;
        n_minute = r_minute;
        n_hour   = r_hour;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;

        unique case (s_axis_tuser)
            CMD_TOGGLE: begin
                n_set = !r_set;
                n_sel = r_set ? FLD_NONE : FLD_SECOND;
            end
            CMD_NEXT: begin
                if (r_set) begin
                    n_sel = (r_sel >= FLD_YEAR) ? FLD_SECOND : r_sel + 3'd1;
                end
            end
            CMD_INC: begin
                if (r_set) begin
                    unique case (r_sel)
                        FLD_SECOND: n_second = (r_second >= SEC_MAX) ? 6'd0
                                             : r_second + 6'd1;
                        FLD_MINUTE: n_minute = (r_minute >= MIN_MAX) ? 6'd0
                                             : r_minute + 6'd1;
                        FLD_HOUR:   n_hour   = (r_hour >= HOUR_MAX) ? 5'd0
                                             : r_hour + 5'd1;
                        FLD_DAY:    n_day    = (r_day >= day_lim) ? 5'd1
                                             : r_day + 5'd1;
                        FLD_MONTH:  n_month  = (r_month >= MONTH_MAX) ? 4'd1
                                             : r_month + 4'd1;
                        FLD_YEAR:   n_year   = (r_year >= YEAR_MAX) ? 7'd0
                                             : r_year + 7'd1;
                        default: begin
                        end
                    endcase
                end
            end
            CMD_DEC: begin
                if (r_set) begin
                    unique case (r_sel)
                        FLD_SECOND: n_second = (r_second == 6'd0) ? SEC_MAX
                                             : r_second - 6'd1;
                        FLD_MINUTE: n_minute = (r_minute == 6'd0) ? MIN_MAX
                                             : r_minute - 6'd1;
                        FLD_HOUR:   n_hour   = (r_hour == 5'd0) ? HOUR_MAX
                                             : r_hour - 5'd1;
                        FLD_DAY:    n_day    = (r_day <= 5'd1) ? day_lim
                                             : r_day - 5'd1;
                        FLD_MONTH:  n_month  = (r_month <= 4'd1) ? MONTH_MAX
                                             : r_month - 4'd1;
                        FLD_YEAR:   n_year   = (r_year == 7'd0) ? YEAR_MAX
                                             : r_year - 7'd1;
                        default: begin
                        end
                    endcase
                end
            end
            CMD_LOAD: begin
                if (!r_set) begin
                    // clamp into each field's range
                    n_second = (ld_sec > {2'd0, SEC_MAX}) ? SEC_MAX : ld_sec[5:0];
                    n_minute = (ld_min > {2'd0, MIN_MAX}) ? MIN_MAX : ld_min[5:0];
                    n_hour   = (ld_hour > {3'd0, HOUR_MAX}) ? HOUR_MAX : ld_hour[4:0];
                    if (ld_day == 8'd0) begin
                        n_day = 5'd1;
                    end else if (ld_day > {3'd0, DAY_MAX}) begin
                        n_day = DAY_MAX;
                    end else begin
                        n_day = ld_day[4:0];
                    end
                    if (ld_month == 8'd0) begin
                        n_month = 4'd1;
                    end else if (ld_month > {4'd0, MONTH_MAX}) begin
                        n_month = MONTH_MAX;
                    end else begin
                        n_month = ld_month[3:0];
                    end
                    n_year = (ld_year > {1'b0, YEAR_MAX}) ? YEAR_MAX : ld_year[6:0];
                end
            end
            default: begin
                // unknown commands leave the state alone
            end
        endcase
    end

    // state updates on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set       <= 1'b0;
            r_sel       <= FLD_NONE;
            r_second    <= 6'd0;
            r_minute    <= 6'd0;
            r_hour      <= 5'd0;
            r_day       <= 5'd0;
            r_month     <= 4'd0;
            r_year      <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_set    <= n_set;
                r_sel    <= n_sel;
                r_second <= n_second;
                r_minute <= n_minute;
                r_hour   <= n_hour;
                r_day    <= n_day;
                r_month  <= n_month;
                r_year   <= n_year;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the state only moves on an accepted beat, which needs the output slot
    // free, so the registered state is the pending result beat
    logic [7:0] sec_bcd, min_bcd, hour_bcd, day_bcd, month_bcd, year_bcd;

    assign sec_bcd   = bin_to_bcd({1'b0, r_second});
    assign min_bcd   = bin_to_bcd({1'b0, r_minute});
    assign hour_bcd  = bin_to_bcd({2'd0, r_hour});
    assign day_bcd   = bin_to_bcd({2'd0, r_day});
    assign month_bcd = bin_to_bcd({3'd0, r_month});
    assign year_bcd  = bin_to_bcd(r_year);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0,
                            year_bcd,
                            month_bcd[4:0],
                            day_bcd[5:0],
                            hour_bcd[5:0],
                            min_bcd[6:0],
                            sec_bcd[6:0],
                            r_sel,
                            r_set};

endmodule

`default_nettype wire
